/* hw/rtl/sysres_pkg.sv */
// shared types and constants for the systematic resampler
`timescale 1ns / 1ps

package sysres_pkg;

    // fixed field widths
    localparam int SAMPLE_W          = 11;
    localparam int INDEX_W           = 10;
    localparam int STATUS_W          = 2;
    localparam int COMMAND_W         = 2;
    localparam int WEIGHT_FIELD_W    = 16;
    localparam int FRACTION_FIELD_W  = 16;
    localparam int WEIGHT_EXT_W      = 32;
    localparam int FRACTION_EXT_W    = 24;
    localparam int SAMPLE_RESET      = 1;

    // command codes
    localparam logic [COMMAND_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [COMMAND_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [COMMAND_W-1:0] CMD_START = 2'd2;
    localparam logic [COMMAND_W-1:0] CMD_DRAW  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_SWEEP = 2'd3;

    // register word index
    localparam logic REG_SAMPLE_COUNT = 1'b0;

    typedef struct packed {
        logic [COMMAND_W-1:0]        command;
        logic [WEIGHT_FIELD_W-1:0]   weight;
        logic [FRACTION_FIELD_W-1:0] random_fraction;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  index;
        logic                last_of_sweep;
        logic [STATUS_W-1:0] status;
    } result_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_CLEAR,
        OP_LOAD,
        OP_START_FAIL,
        OP_START_BEGIN,
        OP_MUL_STEP,
        OP_MUL_LAST,
        OP_DRAW_REJECT,
        OP_CUM_MUL,
        OP_ADVANCE,
        OP_ACCUM,
        OP_DRAW_DONE,
        OP_EMIT
    } dp_op_t;

    // datapath status seen by the controller
    typedef struct packed {
        logic [COMMAND_W-1:0] command;
        logic                 start_ok;
        logic                 draw_ok;
        logic                 mul_last;
        logic                 step_more;
        logic                 slot_free;
    } dp_stat_t;

endpackage

/* hw/rtl/systematic_resampler_top.sv */
// systematic resampler top level: config register, controller and datapath
// clear and load pass through capture, execute and result states; start steps through the
// bit-serial offset-times-sum multiply before its result; a rejected start or draw goes straight to result
// a draw multiplies the running sum by sample count and compares, then per weight stepped over it
// reads, adds, multiplies by sample count and compares again; one item in flight, item_ready rises with result_valid
// reset clears counts, sums and sweep state and sets sample_count to 1; weights stay unknown
`timescale 1ns / 1ps

module systematic_resampler_top
    import sysres_pkg::*;
#(
    parameter int MAX_WEIGHTS   = 1024,
    parameter int WEIGHT_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result
);

    logic [SAMPLE_W-1:0] sample_count_reg, sample_count_next;
    logic                reg_sel;
    dp_op_t              op;
    dp_stat_t            stat;

    // register decode on the word address
    assign reg_sel = (paddr[2] == REG_SAMPLE_COUNT);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? 32'(sample_count_reg) : 32'd0;

    // sample count register write
    always_comb
    begin
        sample_count_next = sample_count_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            sample_count_next = pwdata[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= SAMPLE_W'(SAMPLE_RESET);
        end
        else
        begin
            sample_count_reg <= sample_count_next;
        end
    end

    // controller
    sysres_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .op         (op)
    );

    // datapath
    sysres_datapath #(
        .MAX_WEIGHTS   (MAX_WEIGHTS),
        .WEIGHT_BITS   (WEIGHT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .stat         (stat),
        .item         (item),
        .sample_count (sample_count_reg),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

/* hw/rtl/sysres_datapath.sv */
// resampler datapath: weight memory, sums, product accumulator, compare and result register
`timescale 1ns / 1ps

module sysres_datapath
    import sysres_pkg::*;
#(
    parameter int MAX_WEIGHTS   = 1024,
    parameter int WEIGHT_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dp_op_t              op,
    output dp_stat_t            stat,
    input  item_t               item,
    input  logic [SAMPLE_W-1:0] sample_count,
    output result_t             result,
    output logic                result_valid,
    input  logic                result_ready
);

    localparam int AW  = $clog2(MAX_WEIGHTS);
    localparam int CW  = $clog2(MAX_WEIGHTS + 1);
    localparam int TW  = WEIGHT_BITS + AW;
    localparam int RW  = TW + SAMPLE_W;
    localparam int PW  = RW + FRACTION_BITS;
    localparam int MCW = $clog2(FRACTION_BITS);
    localparam int DW  = SAMPLE_W + 1;

    // weight memory
    logic [WEIGHT_BITS-1:0] store_mem [MAX_WEIGHTS];

    // control state
    logic [CW-1:0]       count_reg, count_next;
    logic [TW-1:0]       total_reg, total_next;
    logic                active_reg, active_next;
    logic [SAMPLE_W-1:0] draw_reg, draw_next;
    logic [AW-1:0]       walk_reg, walk_next;
    logic [TW-1:0]       cum_reg, cum_next;
    logic                out_valid_reg, out_valid_next;

    // payload registers
    item_t                    item_reg;
    logic [FRACTION_BITS-1:0] off_reg;
    logic [MCW-1:0]           mul_cnt_reg;
    logic [PW-1:0]            prod_reg;
    logic [RW-1:0]            cumm_reg;
    logic [WEIGHT_BITS-1:0]   rd_data_reg;
    result_t                  res_reg;
    result_t                  out_reg;

    // derived values
    logic [WEIGHT_EXT_W-1:0]   weight_ext;
    logic [WEIGHT_BITS-1:0]    weight_val;
    logic [FRACTION_EXT_W-1:0] fraction_ext;
    logic [FRACTION_BITS-1:0]  fraction_val;
    logic                      count_full;
    logic [AW-1:0]             walk_inc;
    logic [CW-1:0]             walk_inc_c;
    logic [DW-1:0]             draw_inc;
    logic [DW-1:0]             sample_ext;
    logic [PW-1:0]             rhs;
    logic [PW-1:0]             prod_shift_add;
    logic [PW-1:0]             prod_draw;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;

    assign weight_ext     = WEIGHT_EXT_W'(item_reg.weight);
    assign weight_val     = weight_ext[WEIGHT_BITS-1:0];
    assign fraction_ext   = FRACTION_EXT_W'(item_reg.random_fraction);
    assign fraction_val   = fraction_ext[FRACTION_BITS-1:0];
    assign count_full     = (count_reg >= CW'(MAX_WEIGHTS));
    assign walk_inc       = walk_reg + AW'(1);
    assign walk_inc_c     = CW'(walk_reg) + CW'(1);
    assign draw_inc       = DW'(draw_reg) + DW'(1);
    assign sample_ext     = DW'(sample_count);
    assign rhs            = {cumm_reg, {FRACTION_BITS{1'b0}}};
    assign prod_shift_add = {prod_reg[PW-2:0], 1'b0}
                          + (off_reg[FRACTION_BITS-1] ? PW'(total_reg) : PW'(0));
    assign prod_draw      = prod_reg + PW'({total_reg, {FRACTION_BITS{1'b0}}});

    // memory read port control
    assign rd_en   = (op == OP_START_BEGIN) || (op == OP_ADVANCE);
    assign rd_addr = (op == OP_ADVANCE) ? walk_inc : AW'(0);

    // status toward the controller
    assign stat.command   = item_reg.command;
    assign stat.start_ok  = (count_reg != CW'(0)) && (total_reg != TW'(0));
    assign stat.draw_ok   = active_reg && (draw_reg < sample_count);
    assign stat.mul_last  = (mul_cnt_reg == MCW'(0));
    assign stat.step_more = (walk_inc_c < count_reg) && (prod_reg > rhs);
    assign stat.slot_free = !out_valid_reg || result_ready;

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    // next state of the sweep and store bookkeeping
    always_comb
    begin
        count_next     = count_reg;
        total_next     = total_reg;
        active_next    = active_reg;
        draw_next      = draw_reg;
        walk_next      = walk_reg;
        cum_next       = cum_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (op)
            OP_CLEAR:
            begin
                count_next  = CW'(0);
                total_next  = TW'(0);
                active_next = 1'b0;
                draw_next   = SAMPLE_W'(0);
                walk_next   = AW'(0);
                cum_next    = TW'(0);
            end
            OP_LOAD:
            begin
                active_next = 1'b0;
                draw_next   = SAMPLE_W'(0);
                walk_next   = AW'(0);
                cum_next    = TW'(0);
                if (!count_full)
                begin
                    count_next = count_reg + CW'(1);
                    total_next = total_reg + TW'(weight_val);
                end
            end
            OP_START_FAIL, OP_START_BEGIN, OP_DRAW_REJECT:
            begin
                active_next = 1'b0;
                draw_next   = SAMPLE_W'(0);
                walk_next   = AW'(0);
                cum_next    = TW'(0);
            end
            OP_MUL_LAST:
            begin
                cum_next    = TW'(rd_data_reg);
                active_next = 1'b1;
            end
            OP_ADVANCE:
            begin
                walk_next = walk_inc;
            end
            OP_ACCUM:
            begin
                cum_next = cum_reg + TW'(rd_data_reg);
            end
            OP_DRAW_DONE:
            begin
                draw_next   = draw_inc[SAMPLE_W-1:0];
                active_next = (draw_inc < sample_ext);
            end
            OP_EMIT:
            begin
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= CW'(0);
            total_reg     <= TW'(0);
            active_reg    <= 1'b0;
            draw_reg      <= SAMPLE_W'(0);
            walk_reg      <= AW'(0);
            cum_reg       <= TW'(0);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            total_reg     <= total_next;
            active_reg    <= active_next;
            draw_reg      <= draw_next;
            walk_reg      <= walk_next;
            cum_reg       <= cum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: captured item, products and results
    always_ff @(posedge clk)
    begin
        case (op)
            OP_CAPTURE:
            begin
                item_reg <= item;
            end
            OP_CLEAR:
            begin
                res_reg <= '{index: INDEX_W'(0), last_of_sweep: 1'b0, status: STATUS_OK};
            end
            OP_LOAD:
            begin
                res_reg <= '{index: INDEX_W'(0), last_of_sweep: 1'b0,
                             status: count_full ? STATUS_FULL : STATUS_OK};
            end
            OP_START_FAIL:
            begin
                res_reg <= '{index: INDEX_W'(0), last_of_sweep: 1'b0, status: STATUS_EMPTY};
            end
            OP_START_BEGIN:
            begin
                off_reg     <= fraction_val;
                mul_cnt_reg <= MCW'(FRACTION_BITS - 1);
                prod_reg    <= PW'(0);
            end
            OP_MUL_STEP:
            begin
                prod_reg    <= prod_shift_add;
                off_reg     <= {off_reg[FRACTION_BITS-2:0], 1'b0};
                mul_cnt_reg <= mul_cnt_reg - MCW'(1);
            end
            OP_MUL_LAST:
            begin
                prod_reg <= prod_shift_add;
                off_reg  <= {off_reg[FRACTION_BITS-2:0], 1'b0};
                res_reg  <= '{index: INDEX_W'(0), last_of_sweep: 1'b0, status: STATUS_OK};
            end
            OP_DRAW_REJECT:
            begin
                res_reg <= '{index: INDEX_W'(0), last_of_sweep: 1'b0,
                             status: STATUS_NO_SWEEP};
            end
            OP_CUM_MUL:
            begin
                cumm_reg <= RW'(cum_reg) * RW'(sample_count);
            end
            OP_DRAW_DONE:
            begin
                prod_reg <= prod_draw;
                res_reg  <= '{index: INDEX_W'(walk_reg),
                              last_of_sweep: (draw_inc == sample_ext),
                              status: STATUS_OK};
            end
            OP_EMIT:
            begin
                out_reg <= res_reg;
            end
            default:
            begin
            end
        endcase
    end

    // weight memory write and registered read
    always_ff @(posedge clk)
    begin
        if ((op == OP_LOAD) && !count_full)
        begin
            store_mem[count_reg[AW-1:0]] <= weight_val;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // running sum never passes the total
    a_cum_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        cum_reg <= total_reg)
        else $error("running cumulative exceeds weight total");

    // walk stays on loaded weights during a sweep
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (CW'(walk_reg) < count_reg))
        else $error("walk position beyond loaded weights");

    // a draw only completes inside a sweep
    a_draw_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_DRAW_DONE) |-> active_reg)
        else $error("draw completed without active sweep");

    // no result overwrites one still waiting
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_EMIT) |-> (!out_valid_reg || result_ready))
        else $error("result emitted into a full output register");

endmodule

/* hw/rtl/sysres_ctrl.sv */
// resampler controller: sequences each command through the datapath
`timescale 1ns / 1ps

module sysres_ctrl
    import sysres_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  dp_stat_t stat,
    output dp_op_t   op
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_COMPARE,
        S_ACCUM,
        S_CUMMUL,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;

    assign item_ready = (state_reg == S_IDLE);

    // operation and next state
    always_comb
    begin
        op         = OP_NONE;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op         = OP_CAPTURE;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.command)
                    CMD_CLEAR:
                    begin
                        op         = OP_CLEAR;
                        state_next = S_RESULT;
                    end
                    CMD_LOAD:
                    begin
                        op         = OP_LOAD;
                        state_next = S_RESULT;
                    end
                    CMD_START:
                    begin
                        if (stat.start_ok)
                        begin
                            op         = OP_START_BEGIN;
                            state_next = S_MUL;
                        end
                        else
                        begin
                            op         = OP_START_FAIL;
                            state_next = S_RESULT;
                        end
                    end
                    default:
                    begin
                        if (stat.draw_ok)
                        begin
                            op         = OP_CUM_MUL;
                            state_next = S_COMPARE;
                        end
                        else
                        begin
                            op         = OP_DRAW_REJECT;
                            state_next = S_RESULT;
                        end
                    end
                endcase
            end
            S_MUL:
            begin
                if (stat.mul_last)
                begin
                    op         = OP_MUL_LAST;
                    state_next = S_RESULT;
                end
                else
                begin
                    op = OP_MUL_STEP;
                end
            end
            S_COMPARE:
            begin
                if (stat.step_more)
                begin
                    op         = OP_ADVANCE;
                    state_next = S_ACCUM;
                end
                else
                begin
                    op         = OP_DRAW_DONE;
                    state_next = S_RESULT;
                end
            end
            S_ACCUM:
            begin
                op         = OP_ACCUM;
                state_next = S_CUMMUL;
            end
            S_CUMMUL:
            begin
                op         = OP_CUM_MUL;
                state_next = S_COMPARE;
            end
            S_RESULT:
            begin
                if (stat.slot_free)
                begin
                    op         = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
